/* hdl/cwec_pkg.sv */
// shared constants and types for the cross-window extremum classifier
package cwec_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // configuration port
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // frame dimension limits and reset size
    localparam int DIM_MIN   = 3;
    localparam int DIM_RESET = 8;

    // result classes
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_MAX    = 2'd0,
        KIND_MIN    = 2'd1,
        KIND_SADDLE = 2'd2
    } kind_t;

endpackage

/* hdl/cwec_ram.sv */
// generic simple dual-port ram with registered read
module cwec_ram
    #(
        parameter int DATA_W = 32,
        parameter int DEPTH  = 1024,
        localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic              aclk,
        input  logic              wr_en,
        input  logic [ADDR_W-1:0] wr_addr,
        input  logic [DATA_W-1:0] wr_data,
        input  logic              rd_en,
        input  logic [ADDR_W-1:0] rd_addr,
        output logic [DATA_W-1:0] rd_data
    );

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/cwec_cell.sv */
// one column cell of the window: the two stored samples of a column
module cwec_cell
    #(
        parameter int SAMPLE_BITS = 16
    )
    (
        input  logic                          aclk,
        input  logic                          shift_en,
        input  logic signed [SAMPLE_BITS-1:0] up_i,
        input  logic signed [SAMPLE_BITS-1:0] centre_i,
        output logic signed [SAMPLE_BITS-1:0] up_o,
        output logic signed [SAMPLE_BITS-1:0] centre_o
    );

    logic signed [SAMPLE_BITS-1:0] up_reg;
    logic signed [SAMPLE_BITS-1:0] centre_reg;

    // take the column from the neighbour on a shift
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            up_reg     <= up_i;
            centre_reg <= centre_i;
        end
    end

    assign up_o     = up_reg;
    assign centre_o = centre_reg;

endmodule

/* hdl/cwec_classify.sv */
// cross compare of a centre sample with its four neighbours
module cwec_classify
    import cwec_pkg::*;
    #(
        parameter int SAMPLE_BITS = 16
    )
    (
        input  logic                          interior,
        input  logic signed [SAMPLE_BITS-1:0] left,
        input  logic signed [SAMPLE_BITS-1:0] centre,
        input  logic signed [SAMPLE_BITS-1:0] right,
        input  logic signed [SAMPLE_BITS-1:0] up,
        input  logic signed [SAMPLE_BITS-1:0] down,
        output logic                          hit,
        output kind_t                         kind
    );

    typedef enum logic [1:0] {
        MARK_NONE,
        MARK_PEAK,
        MARK_VALLEY
    } mark_t;

    // strict peak or valley of b between a and c
    function automatic mark_t mark_dir(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input logic signed [SAMPLE_BITS-1:0] c
    );
        mark_t m;
        m = MARK_NONE;
        if ((a < b) && (b > c)) begin
            m = MARK_PEAK;
        end else if ((a > b) && (b < c)) begin
            m = MARK_VALLEY;
        end
        return m;
    endfunction

    mark_t h_mark;
    mark_t v_mark;

    assign h_mark = mark_dir(left, centre, right);
    assign v_mark = mark_dir(up, centre, down);

    // both directions must mark
    always_comb begin
        hit  = interior && (h_mark != MARK_NONE) && (v_mark != MARK_NONE);
        kind = KIND_SADDLE;
        if ((h_mark == MARK_PEAK) && (v_mark == MARK_PEAK)) begin
            kind = KIND_MAX;
        end else if ((h_mark == MARK_VALLEY) && (v_mark == MARK_VALLEY)) begin
            kind = KIND_MIN;
        end
    end

endmodule

/* hdl/cross_window_extremum_classifier.sv */
// top level: line store, window cells, counters and result register
//
//  channel | ports                         | direction | word
//  --------+-------------------------------+-----------+-------------------------------
//  input   | s_valid / s_ready             | in        | s_pixel_value
//  result  | m_valid / m_ready             | out       | m_point_kind, _value, _row, _col
//  config  | cfg_we                        | in        | cfg_index, cfg_wdata
//
//  one input word per cycle while the result side keeps up; a result leaves
//  through a single output register in the cycle after the word below its centre
//  the line store is one ram holding the two previous rows per column; the
//  window runs two columns ahead of it through the ram read register
//  after reset and after every configuration write the window is refilled
//  from the ram in ST_FILL_CUR, then ST_FILL_NEXT, while s_ready stays low
//  a stalled result holds s_ready low only while the output register is full
module cross_window_extremum_classifier
    import cwec_pkg::*;
    #(
        parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
        parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
        parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
        localparam int COL_W = $clog2(MAX_WIDTH),
        localparam int ROW_W = $clog2(MAX_HEIGHT)
    )
    (
        input  logic                          aclk,
        input  logic                          aresetn,
        // input words
        input  logic                          s_valid,
        output logic                          s_ready,
        input  logic signed [SAMPLE_BITS-1:0] s_pixel_value,
        // results
        output logic                          m_valid,
        input  logic                          m_ready,
        output logic [KIND_W-1:0]             m_point_kind,
        output logic signed [SAMPLE_BITS-1:0] m_point_value,
        output logic [ROW_W-1:0]              m_point_row,
        output logic [COL_W-1:0]              m_point_col,
        // configuration
        input  logic                          cfg_we,
        input  logic [CFG_INDEX_W-1:0]        cfg_index,
        input  logic [CFG_DATA_W-1:0]         cfg_wdata
    );

    localparam int WD = $clog2(MAX_WIDTH + 1);
    localparam int HD = $clog2(MAX_HEIGHT + 1);
    localparam int ENTRY_W = 2 * SAMPLE_BITS;
    localparam int WIDTH_RESET  = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
    localparam int HEIGHT_RESET = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

    typedef enum logic [1:0] {
        ST_FILL_CUR,
        ST_FILL_NEXT,
        ST_RUN
    } state_t;

    state_t           state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WD-1:0]    width_reg, width_next;
    logic [HD-1:0]    height_reg, height_next;
    logic             m_valid_reg, m_valid_next;

    logic [KIND_W-1:0]             kind_reg;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic [ROW_W-1:0]              prow_reg;
    logic [COL_W-1:0]              pcol_reg;

    logic                          accept;
    logic [COL_W-1:0]              col_eff;
    logic [ROW_W-1:0]              row_eff;
    logic [COL_W-1:0]              col_1;
    logic [COL_W-1:0]              col_2;
    logic                          col_wrap;
    logic [ROW_W-1:0]              row_inc;
    logic                          interior;

    logic                          ram_rd_en;
    logic [COL_W-1:0]              ram_rd_addr;
    logic [ENTRY_W-1:0]            ram_rd_data;
    logic [ENTRY_W-1:0]            ram_wr_data;

    logic                          cur_load;
    logic signed [SAMPLE_BITS-1:0] up_s;
    logic signed [SAMPLE_BITS-1:0] centre_s;
    logic signed [SAMPLE_BITS-1:0] prev_centre_s;
    logic signed [SAMPLE_BITS-1:0] left_s;
    logic signed [SAMPLE_BITS-1:0] right_s;

    logic                          hit;
    kind_t                         kind;

    // next column with wrap at the frame width
    function automatic logic [COL_W-1:0] col_step(
        input logic [COL_W-1:0] c,
        input logic [WD-1:0]    w
    );
        logic [WD-1:0] cp;
        cp = WD'(c) + WD'(1);
        return (cp >= w) ? '0 : cp[COL_W-1:0];
    endfunction

    // clamp a written dimension into its legal range
    function automatic logic [WD-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
        logic [WD-1:0] r;
        if (32'(v) < DIM_MIN) begin
            r = WD'(DIM_MIN);
        end else if (32'(v) > MAX_WIDTH) begin
            r = WD'(MAX_WIDTH);
        end else begin
            r = WD'(v);
        end
        return r;
    endfunction

    function automatic logic [HD-1:0] clamp_height(input logic [CFG_DATA_W-1:0] v);
        logic [HD-1:0] r;
        if (32'(v) < DIM_MIN) begin
            r = HD'(DIM_MIN);
        end else if (32'(v) > MAX_HEIGHT) begin
            r = HD'(MAX_HEIGHT);
        end else begin
            r = HD'(v);
        end
        return r;
    endfunction

    // handshake
    assign s_ready = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // position arithmetic
    assign col_eff  = (WD'(col_reg) >= width_reg) ? '0 : col_reg;
    assign row_eff  = (HD'(row_reg) >= height_reg) ? '0 : row_reg;
    assign col_1    = col_step(col_reg, width_reg);
    assign col_2    = col_step(col_1, width_reg);
    assign col_wrap = (WD'(col_reg) + WD'(1)) >= width_reg;
    assign row_inc  = ((HD'(row_reg) + HD'(1)) >= height_reg) ? '0 : (row_reg + ROW_W'(1));
    assign interior = (row_reg >= ROW_W'(2)) && (col_reg != '0) && !col_wrap;

    // line store read: current column, then the one after, then two ahead
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = col_2;
        unique case (state_reg)
            ST_FILL_CUR: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = col_eff;
            end
            ST_FILL_NEXT: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = col_1;
            end
            ST_RUN: begin
                ram_rd_en   = accept;
                ram_rd_addr = col_2;
            end
            default: begin
                ram_rd_en   = 1'b0;
                ram_rd_addr = col_2;
            end
        endcase
    end

    // entry layout: upper half row two above, lower half row directly above
    assign ram_wr_data = {centre_s, s_pixel_value};

    cwec_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // window cells: ram read register feeds the current column, which feeds the left one
    assign cur_load = accept || (state_reg == ST_FILL_NEXT);

    cwec_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell_cur (
        .aclk     (aclk),
        .shift_en (cur_load),
        .up_i     (ram_rd_data[ENTRY_W-1:SAMPLE_BITS]),
        .centre_i (ram_rd_data[SAMPLE_BITS-1:0]),
        .up_o     (up_s),
        .centre_o (centre_s)
    );

    cwec_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell_left (
        .aclk     (aclk),
        .shift_en (accept),
        .up_i     (up_s),
        .centre_i (centre_s),
        .up_o     (),
        .centre_o (prev_centre_s)
    );

    assign right_s = ram_rd_data[SAMPLE_BITS-1:0];
    assign left_s  = (col_reg == '0) ? centre_s : prev_centre_s;

    cwec_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .interior (interior),
        .left     (left_s),
        .centre   (centre_s),
        .right    (right_s),
        .up       (up_s),
        .down     (s_pixel_value),
        .hit      (hit),
        .kind     (kind)
    );

    // control next state
    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        m_valid_next = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_FILL_CUR: begin
                col_next   = col_eff;
                row_next   = row_eff;
                state_next = ST_FILL_NEXT;
            end
            ST_FILL_NEXT: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (accept) begin
                    m_valid_next = hit;
                    col_next     = col_1;
                    if (col_wrap) begin
                        row_next = row_inc;
                    end
                end
            end
            default: begin
                state_next = ST_FILL_CUR;
            end
        endcase

        // register write, then refill the window for the new geometry
        if (cfg_we) begin
            state_next = ST_FILL_CUR;
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = clamp_width(cfg_wdata);
                REG_FRAME_HEIGHT: height_next = clamp_height(cfg_wdata);
                default: begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_FILL_CUR;
            col_reg     <= '0;
            row_reg     <= '0;
            width_reg   <= WD'(WIDTH_RESET);
            height_reg  <= HD'(HEIGHT_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (accept && hit) begin
            kind_reg  <= kind;
            value_reg <= centre_s;
            prow_reg  <= row_reg - ROW_W'(1);
            pcol_reg  <= col_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_point_kind  = kind_reg;
    assign m_point_value = value_reg;
    assign m_point_row   = prow_reg;
    assign m_point_col   = pcol_reg;

endmodule

/* tb/cross_window_extremum_classifier_tb.sv */
// testbench for the cross-window extremum classifier: streamed frames checked against a predictor
`timescale 1ns / 1ps

module cross_window_extremum_classifier_tb;
    import cwec_pkg::*;

    localparam int SAMPLE_W      = DEF_SAMPLE_BITS;
    localparam int POS_W         = $clog2(DEF_MAX_WIDTH);
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 900;
    localparam int EDGE_WORDS    = 300;

    // strict comparison outcome along one direction
    localparam int DIR_NONE   = 0;
    localparam int DIR_PEAK   = 1;
    localparam int DIR_VALLEY = -1;

    // directed 4 x 5 frame: maximum, minimum, both saddle kinds, a tie each way
    localparam int DIRECTED_GRID [20] = '{
        0,      -100,   0,      0,
        1,      32767,  -32768, 5,
        -7,     10,     3,      50,
        20,     20,     -1,     0,
        0,      0,      -1,     0
    };

    typedef enum int {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct {
        kind_t                      kind;
        logic signed [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]           row;
        logic [POS_W-1:0]           col;
    } point_t;

    // line stores, counters and registers mirrored, plus the queue of points due
    class extremum_scoreboard;
        logic signed [SAMPLE_W-1:0] older_rows [DEF_MAX_WIDTH];
        logic signed [SAMPLE_W-1:0] newer_rows [DEF_MAX_WIDTH];
        bit                         older_ok   [DEF_MAX_WIDTH];
        bit                         newer_ok   [DEF_MAX_WIDTH];
        logic signed [SAMPLE_W-1:0] left_centre;
        int                         row_cnt;
        int                         col_cnt;
        logic [CFG_DATA_W-1:0]      width_reg;
        logic [CFG_DATA_W-1:0]      height_reg;
        point_t                     expected_points [$];
        int                         errors;

        function new();
            foreach (older_rows[i]) begin
                older_rows[i] = '0;
                newer_rows[i] = '0;
                older_ok[i]   = 1'b0;
                newer_ok[i]   = 1'b0;
            end
            left_centre = '0;
            row_cnt     = 0;
            col_cnt     = 0;
            width_reg   = CFG_DATA_W'(DIM_RESET);
            height_reg  = CFG_DATA_W'(DIM_RESET);
            errors      = 0;
        endfunction

        function int clamp_dim(int v, int maxv);
            if (v < DIM_MIN) return DIM_MIN;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, int val);
            if (idx == REG_FRAME_WIDTH) width_reg = CFG_DATA_W'(val);
            else if (idx == REG_FRAME_HEIGHT) height_reg = CFG_DATA_W'(val);
        endfunction

        // true when both stores hold data written at some time for every column below w
        function bit columns_written(int w);
            int c;
            for (c = 0; c < w; c++) begin
                if (!(older_ok[c] && newer_ok[c])) return 1'b0;
            end
            return 1'b1;
        endfunction

        function int direction(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
                               logic signed [SAMPLE_W-1:0] c);
            if (a < b && b > c) return DIR_PEAK;
            if (a > b && b < c) return DIR_VALLEY;
            return DIR_NONE;
        endfunction

        // accepted word: classify the centre above it, then shift the stores
        function void note_pixel(logic signed [SAMPLE_W-1:0] px);
            int                         w;
            int                         h;
            int                         r;
            int                         c;
            int                         hm;
            int                         vm;
            logic signed [SAMPLE_W-1:0] centre;
            logic signed [SAMPLE_W-1:0] left;
            point_t                     p;
            w = clamp_dim(int'(width_reg), DEF_MAX_WIDTH);
            h = clamp_dim(int'(height_reg), DEF_MAX_HEIGHT);
            r = row_cnt;
            c = col_cnt;
            if (r >= h) r = 0;
            if (c >= w) c = 0;
            centre = newer_rows[c];
            left   = (c == 0) ? centre : left_centre;
            if (r >= 2 && c >= 1 && c + 1 < w) begin
                hm = direction(left, centre, newer_rows[c+1]);
                vm = direction(older_rows[c], centre, px);
                if (hm != DIR_NONE && vm != DIR_NONE) begin
                    if (hm == DIR_PEAK && vm == DIR_PEAK) p.kind = KIND_MAX;
                    else if (hm == DIR_VALLEY && vm == DIR_VALLEY) p.kind = KIND_MIN;
                    else p.kind = KIND_SADDLE;
                    p.value = centre;
                    p.row   = POS_W'(r - 1);
                    p.col   = POS_W'(c);
                    expected_points.push_back(p);
                end
            end
            left_centre   = centre;
            older_ok[c]   = newer_ok[c];
            older_rows[c] = centre;
            newer_rows[c] = px;
            newer_ok[c]   = 1'b1;
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col_cnt = c;
            row_cnt = r;
        endfunction

        function void check_point(logic [KIND_W-1:0] kind, logic signed [SAMPLE_W-1:0] value,
                                  logic [POS_W-1:0] row, logic [POS_W-1:0] col);
            point_t want;
            if (expected_points.size() == 0) begin
                $error("point with none due: kind %0d value %0d row %0d col %0d",
                       kind, value, row, col);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            if (kind !== want.kind) begin
                $error("point_kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (value !== want.value) begin
                $error("point_value: expected %0d, got %0d", want.value, value);
                errors++;
            end
            if (row !== want.row) begin
                $error("point_row: expected %0d, got %0d", want.row, row);
                errors++;
            end
            if (col !== want.col) begin
                $error("point_col: expected %0d, got %0d", want.col, col);
                errors++;
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [SAMPLE_W-1:0]   s_pixel_value;
    logic                         m_valid;
    logic                         m_ready;
    logic [KIND_W-1:0]            m_point_kind;
    logic signed [SAMPLE_W-1:0]   m_point_value;
    logic [POS_W-1:0]             m_point_row;
    logic [POS_W-1:0]             m_point_col;
    logic                         cfg_we;
    logic [CFG_INDEX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_wdata;

    extremum_scoreboard sb;
    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    int                 cycle_count = 0;

    cross_window_extremum_classifier DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_kind  (m_point_kind),
        .m_point_value (m_point_value),
        .m_point_row   (m_point_row),
        .m_point_col   (m_point_col),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls, check every accepted word
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_point(m_point_kind, m_point_value, m_point_row, m_point_col);
    end

    function automatic logic signed [SAMPLE_W-1:0] random_pixel();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 50) return SAMPLE_W'($urandom);
        if (pick < 85) return SAMPLE_W'($urandom_range(4, 0) - 2);
        case ($urandom_range(3, 0))
            0: return SAMPLE_W'(-32768);
            1: return SAMPLE_W'(-32767);
            2: return SAMPLE_W'(32766);
            default: return SAMPLE_W'(32767);
        endcase
    endfunction

    function automatic void set_pace(pace_t pace);
        case (pace)
            PACE_FULL: begin
                idle_pct = 0;  stall_pct = 0;
            end
            PACE_SENDER_IDLE: begin
                idle_pct = 69; stall_pct = 0;
            end
            PACE_RECEIVER_STALL: begin
                idle_pct = 0;  stall_pct = 69;
            end
            default: begin
                idle_pct = 21; stall_pct = 21;
            end
        endcase
    endfunction

    // one input word, with random idle cycles ahead of it
    task automatic send_pixel(input logic signed [SAMPLE_W-1:0] px);
        while ($urandom_range(99, 0) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_value <= px;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(px);
    endtask

    // wait until every due point has left, then let the pipeline drain
    task automatic settle();
        @(posedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_register(idx, val);
    endtask

    // a wider frame could read columns never stored: end the current frame first,
    // shrunk to the smallest size where its columns are stored, so that only a few words are needed
    task automatic configure(input int w_raw, input int h_raw);
        if (!sb.columns_written(sb.clamp_dim(w_raw, DEF_MAX_WIDTH))) begin
            if (sb.columns_written(DIM_MIN)) begin
                write_register(REG_FRAME_WIDTH, DIM_MIN);
                write_register(REG_FRAME_HEIGHT, DIM_MIN);
            end
            while (sb.row_cnt != 0 || sb.col_cnt != 0) send_pixel(random_pixel());
            s_valid <= 1'b0;
            settle();
        end
        write_register(REG_FRAME_WIDTH, w_raw);
        write_register(REG_FRAME_HEIGHT, h_raw);
    endtask

    task automatic run_phase(input int count, input pace_t pace, input int pause_at);
        int i;
        set_pace(pace);
        for (i = 0; i < count; i++) begin
            send_pixel(random_pixel());
            // sender holds off until the result side has caught up
            if (i == pause_at) begin
                s_valid <= 1'b0;
                settle();
            end
        end
        s_valid <= 1'b0;
        settle();
    endtask

    // stimulus
    initial begin
        int    i;
        int    sent;
        int    phase;
        int    count;
        int    w_raw;
        int    h_raw;
        sb = new();
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_pixel_value <= '0;
        m_ready       <= 1'b1;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_FRAME_WIDTH;
        cfg_wdata     <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        settle();

        // directed frame covering every class, both extremes and ties
        configure(4, 5);
        set_pace(PACE_FULL);
        for (i = 0; i < 20; i++) send_pixel(SAMPLE_W'(DIRECTED_GRID[i]));
        s_valid <= 1'b0;
        settle();

        // start of the tallest frame at the narrowest width, then of the widest frame,
        // height below range
        configure(3, 1024);
        run_phase(EDGE_WORDS, PACE_FULL, -1);
        configure(2047, 1);
        run_phase(EDGE_WORDS, PACE_FULL, -1);

        // random sizes, changed mid-frame, under every pacing
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(9, 0)) inside
                0:       w_raw = $urandom_range(2, 0);
                [7:8]:   w_raw = $urandom_range(40, 13);
                9:       w_raw = $urandom_range(2047, 1000);
                default: w_raw = $urandom_range(12, 3);
            endcase
            case ($urandom_range(9, 0)) inside
                [0:1]:   h_raw = $urandom_range(2, 0);
                9:       h_raw = $urandom_range(2047, 1000);
                default: h_raw = $urandom_range(10, 3);
            endcase
            configure(w_raw, h_raw);
            count = $urandom_range(200, 40);
            run_phase(count, pace_t'(phase % 4),
                      (phase == 0 || $urandom_range(2, 0) == 0) ? count / 2 : -1);
            sent += count;
            phase++;
        end

        if (sb.errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

/* cross_window_extremum_classifier.f */
hdl/cwec_pkg.sv
hdl/cwec_ram.sv
hdl/cwec_cell.sv
hdl/cwec_classify.sv
hdl/cross_window_extremum_classifier.sv
tb/cross_window_extremum_classifier_tb.sv
